// ===== hw/rtl/sqdpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// sqdpcm_pkg
// Shared types, constants and the delta squarer for the square-table DPCM
// audio decoder.
// ----------------------------------------------------------------------------
package sqdpcm_pkg;

  // Number of header bytes at the head of every chunk.
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned POS_W = $clog2(HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LOW_BYTE = POS_W'(HEADER_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LOAD     = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_DELTA    = POS_W'(HEADER_BYTES);

  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
    logic       chunk_end;
  } item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               channel_index;
    logic               last_of_chunk;
  } result_t;

  // Magnitude of the delta: the low seven bits of the code, squared.
  function automatic logic [13:0] square_mag(input logic [6:0] m);
    logic [13:0] mw;
    begin
      mw = {7'd0, m};
      return 14'(mw * mw);
    end
  endfunction

endpackage

// ===== hw/rtl/square_dpcm_audio_decoder.sv =====
// ----------------------------------------------------------------------------
// square_dpcm_audio_decoder
// Square-table DPCM audio decoder, one chunk byte per request.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle unless a delta byte waits on an occupied
// output register. A byte lands in the input register, the decode stage adds
// the squared delta to the channel predictor and clamps it, and the sample
// waits in the output register until it is taken. The predictor
// feedback closes inside the decode stage, so back-to-back bytes of the same
// channel need no stall. The eight header bytes of each chunk produce no
// sample; stereo_mode must only be changed while no request is in flight.
module square_dpcm_audio_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_chunk_start,
  input  logic               in_chunk_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_value,
  output logic               out_channel_index,
  output logic               out_last_of_chunk
);

  logic                stereo_r;
  sqdpcm_pkg::item_t   in_item;
  sqdpcm_pkg::item_t   item;
  logic                item_valid;
  logic                consume;
  logic                out_free;
  logic                res_valid;
  sqdpcm_pkg::result_t res;
  logic                out_valid_r, out_valid_nxt;
  sqdpcm_pkg::result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
    end else if (cfg_wr_en) begin
      stereo_r <= cfg_wr_data;
    end
  end

  assign in_item.data_byte   = in_data_byte;
  assign in_item.chunk_start = in_chunk_start;
  assign in_item.chunk_end   = in_chunk_end;

  sqdpcm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  assign out_free = !out_valid_r || out_ready;

  sqdpcm_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .stereo_mode (stereo_r),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (out_free),
    .consume     (consume),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_value  = out_r.sample_value;
  assign out_channel_index = out_r.channel_index;
  assign out_last_of_chunk = out_r.last_of_chunk;

  // A new sample may only be written over an empty or departing one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_ready))
    else $error("sample written into an occupied output register");

  // The input side stalls only while the input register is still full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (item_valid && !consume))
    else $error("input stalled with an empty input register");

  // A stalled request in the input register must be held by output back-pressure.
  a_stall_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !consume) |-> (out_valid_r && !out_ready))
    else $error("request held without output back-pressure");

endmodule

// ===== hw/rtl/sqdpcm_in_stage.sv =====
// ----------------------------------------------------------------------------
// sqdpcm_in_stage
// Input register: holds one request until the decode stage consumes it.
// ----------------------------------------------------------------------------
module sqdpcm_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqdpcm_pkg::item_t   in_item,
  input  logic                consume,
  output logic                item_valid,
  output sqdpcm_pkg::item_t   item
);

  logic              valid_r;
  logic              valid_nxt;
  sqdpcm_pkg::item_t item_r;
  logic              take;

  // The stage refills in the same cycle that its request moves on.
  assign in_ready = !valid_r || consume;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/sqdpcm_decode.sv =====
// ----------------------------------------------------------------------------
// sqdpcm_decode
// Decode stage: header tracking, predictor state and the delta update with
// clamping to signed 16 bits.
// ----------------------------------------------------------------------------
module sqdpcm_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 stereo_mode,
  input  logic                 item_valid,
  input  sqdpcm_pkg::item_t    item,
  input  logic                 out_free,
  output logic                 consume,
  output logic                 res_valid,
  output sqdpcm_pkg::result_t  res
);

  localparam int unsigned POS_W = sqdpcm_pkg::POS_W;

  logic [POS_W-1:0]   pos_r,  pos_nxt;
  logic [7:0]         hdr_r,  hdr_nxt;
  logic signed [15:0] pred_r   [2];
  logic signed [15:0] pred_nxt [2];
  logic               chan_r, chan_nxt;

  logic [POS_W-1:0]   pos_eff;
  logic               is_delta;
  logic               ch;
  logic [13:0]        mag;
  logic signed [16:0] delta;
  logic signed [16:0] sum;
  logic signed [15:0] clamped;

  assign pos_eff  = item.chunk_start ? '0 : pos_r;
  assign is_delta = (pos_eff == sqdpcm_pkg::POS_DELTA);
  assign ch       = stereo_mode & chan_r;

  assign mag   = sqdpcm_pkg::square_mag(item.data_byte[6:0]);
  assign delta = item.data_byte[7] ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
  assign sum   = $signed({pred_r[ch][15], pred_r[ch]}) + delta;

  // A sum whose top two bits differ has left the 16-bit range.
  always_comb begin
    if (sum[16] != sum[15]) begin
      clamped = sum[16] ? sqdpcm_pkg::SAMPLE_MIN : sqdpcm_pkg::SAMPLE_MAX;
    end else begin
      clamped = sum[15:0];
    end
  end

  // Header bytes never wait on the output register.
  assign consume   = item_valid && (!is_delta || out_free);
  assign res_valid = item_valid && is_delta && out_free;

  assign res.sample_value  = clamped;
  assign res.channel_index = ch;
  assign res.last_of_chunk = item.chunk_end;

  always_comb begin
    pos_nxt     = pos_r;
    hdr_nxt     = hdr_r;
    pred_nxt[0] = pred_r[0];
    pred_nxt[1] = pred_r[1];
    chan_nxt    = chan_r;
    if (consume) begin
      if (!is_delta) begin
        if (pos_eff == sqdpcm_pkg::POS_LOW_BYTE) begin
          hdr_nxt = item.data_byte;
        end else if (pos_eff == sqdpcm_pkg::POS_LOAD) begin
          if (stereo_mode) begin
            pred_nxt[0] = {item.data_byte, 8'h00};
            pred_nxt[1] = {hdr_r, 8'h00};
          end else begin
            pred_nxt[0] = {item.data_byte, hdr_r};
            pred_nxt[1] = '0;
          end
          chan_nxt = 1'b0;
        end
        pos_nxt = pos_eff + POS_W'(1);
      end else begin
        pred_nxt[ch] = clamped;
        pos_nxt      = pos_eff;
        if (stereo_mode) begin
          chan_nxt = ~ch;
        end
      end
      if (item.chunk_end) begin
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hdr_r     <= '0;
      pred_r[0] <= '0;
      pred_r[1] <= '0;
      chan_r    <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      hdr_r     <= hdr_nxt;
      pred_r[0] <= pred_nxt[0];
      pred_r[1] <= pred_nxt[1];
      chan_r    <= chan_nxt;
    end
  end

endmodule
